### src/assert_macros.svh
// assertion macros for the evaluator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// implication whose consequent is checked on the next clock, outside reset
`define ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

### src/pse_pkg.sv
// package for the postfix stack evaluator: types, codes, sizes
package pse_pkg;

   localparam int StackDepth = 64;
   localparam int VarCount   = 256;
   localparam int SpWidth    = $clog2(StackDepth + 1);
   localparam int SaWidth    = $clog2(StackDepth);
   localparam int VaWidth    = $clog2(VarCount);

   typedef enum logic [1:0] {
      ACT_PUSH_LIT = 2'd0,
      ACT_PUSH_VAR = 2'd1,
      ACT_APPLY    = 2'd2,
      ACT_FINISH   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_POW = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ERR_OK        = 3'd0,
      ERR_UNDERFLOW = 3'd1,
      ERR_OVERFLOW  = 3'd2,
      ERR_DIVZERO   = 3'd3,
      ERR_UNSET     = 3'd4,
      ERR_NEGEXP    = 3'd5
   } err_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDA,
      ST_RDB,
      ST_RDWAIT,
      ST_OPER,
      ST_DIV,
      ST_POW_MUL,
      ST_POW_SQ,
      ST_WRITE,
      ST_VARRD,
      ST_VARWAIT,
      ST_FINRD,
      ST_FINWAIT,
      ST_FINOUT
   } state_type;

   typedef struct packed {
      action_type  action;
      logic signed [31:0] value;
      logic [7:0]  var_index;
      logic [2:0]  op;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic [7:0]  target_index;
      logic [2:0]  error_code;
   } rsp_type;

endpackage

### src/postfix_stack_evaluator.sv
// postfix evaluator: stack, variable memory, sequencer, shared multiplier and iterative divide/power
// push writes the stack; apply reads two operands, operates, writes back; finish reads entry 0
// throughput: one request at a time; busy stays high until the request is done
// the divide does one quotient bit per cycle, the power one multiply per cycle
// the single result is shown for one cycle on rsp_valid and cannot be stalled
// synchronous reset clears stack pointer, error, valid bits and the sequencer
`include "assert_macros.svh"

module postfix_stack_evaluator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pse_pkg::req_type req_data,
   output logic             rsp_valid,
   output pse_pkg::rsp_type rsp_data
);

   pse_pkg::state_type state_ff, state_in;
   pse_pkg::req_type   req_ff, req_in;
   logic [pse_pkg::SpWidth-1:0] sp_ff, sp_in;
   pse_pkg::err_type   err_ff, err_in;
   logic [pse_pkg::VarCount-1:0] vvalid_ff, vvalid_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   pse_pkg::rsp_type rsp_ff, rsp_in;

   logic [31:0] stack_mem [pse_pkg::StackDepth];
   logic [31:0] var_mem [pse_pkg::VarCount];
   logic [31:0] stk_rd_ff, var_rd_ff;
   logic [pse_pkg::SaWidth-1:0] stk_ra, stk_wa;
   logic        stk_we, var_we;
   logic [31:0] stk_wd, var_wd;
   logic [pse_pkg::VaWidth-1:0] var_ra, var_wa;
   logic [31:0] mul_a, mul_b, mul_p;
   logic [32:0] trial;

   assign busy      = (state_ff != pse_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign mul_p     = mul_a * mul_b;
   assign var_ra    = req_ff.var_index[pse_pkg::VaWidth-1:0];
   assign var_wa    = req_ff.var_index[pse_pkg::VaWidth-1:0];
   assign trial     = {rem_ff, a_ff[31]} - {1'b0, b_ff};

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_wa] <= stk_wd;
      end
      stk_rd_ff <= stack_mem[stk_ra];
      if (var_we) begin
         var_mem[var_wa] <= var_wd;
      end
      var_rd_ff <= var_mem[var_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pse_pkg::ST_IDLE;
         sp_ff        <= '0;
         err_ff       <= pse_pkg::ERR_OK;
         vvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         err_ff       <= err_in;
         vvalid_ff    <= vvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      rsp_ff <= rsp_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pse_pkg::ST_IDLE: begin
            if (start) begin
               case (req_data.action)
                  pse_pkg::ACT_PUSH_LIT: state_in = pse_pkg::ST_WRITE;
                  pse_pkg::ACT_PUSH_VAR: state_in = pse_pkg::ST_VARRD;
                  pse_pkg::ACT_APPLY:    state_in = pse_pkg::ST_RDA;
                  default:               state_in = pse_pkg::ST_FINRD;
               endcase
            end
         end
         pse_pkg::ST_RDA: begin
            if (sp_ff < pse_pkg::SpWidth'(2)) begin
               state_in = pse_pkg::ST_IDLE;
            end else begin
               state_in = pse_pkg::ST_RDB;
            end
         end
         pse_pkg::ST_RDB:     state_in = pse_pkg::ST_RDWAIT;
         pse_pkg::ST_RDWAIT:  state_in = pse_pkg::ST_OPER;
         pse_pkg::ST_OPER: begin
            if (req_ff.op == pse_pkg::OP_DIV && b_ff != '0) begin
               state_in = pse_pkg::ST_DIV;
            end else if (req_ff.op == pse_pkg::OP_POW && !b_ff[31] && b_ff != '0) begin
               state_in = pse_pkg::ST_POW_MUL;
            end else begin
               state_in = pse_pkg::ST_WRITE;
            end
         end
         pse_pkg::ST_DIV: begin
            if (cnt_ff == 6'd31) begin
               state_in = pse_pkg::ST_WRITE;
            end
         end
         pse_pkg::ST_POW_MUL: state_in = pse_pkg::ST_POW_SQ;
         pse_pkg::ST_POW_SQ: begin
            if (b_ff[31:1] == '0) begin
               state_in = pse_pkg::ST_WRITE;
            end else begin
               state_in = pse_pkg::ST_POW_MUL;
            end
         end
         pse_pkg::ST_WRITE:   state_in = pse_pkg::ST_IDLE;
         pse_pkg::ST_VARRD: begin
            if (vvalid_ff[var_ra]) begin
               state_in = pse_pkg::ST_VARWAIT;
            end else begin
               state_in = pse_pkg::ST_IDLE;
            end
         end
         pse_pkg::ST_VARWAIT: state_in = pse_pkg::ST_WRITE;
         pse_pkg::ST_FINRD:   state_in = pse_pkg::ST_FINWAIT;
         pse_pkg::ST_FINWAIT: state_in = pse_pkg::ST_FINOUT;
         pse_pkg::ST_FINOUT:  state_in = pse_pkg::ST_IDLE;
         default:             state_in = pse_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in       = req_ff;
      sp_in        = sp_ff;
      err_in       = err_ff;
      vvalid_in    = vvalid_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      stk_ra       = '0;
      stk_we       = 1'b0;
      stk_wa       = '0;
      stk_wd       = acc_ff;
      var_we       = 1'b0;
      var_wd       = '0;
      mul_a        = acc_ff;
      mul_b        = a_ff;
      case (state_ff)
         pse_pkg::ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               acc_in = req_data.value;
            end
         end
         pse_pkg::ST_RDA: begin
            stk_ra = sp_ff[pse_pkg::SaWidth-1:0] - pse_pkg::SaWidth'(2);
            if (sp_ff < pse_pkg::SpWidth'(2) && err_ff == pse_pkg::ERR_OK) begin
               err_in = pse_pkg::ERR_UNDERFLOW;
            end
         end
         pse_pkg::ST_RDB: begin
            stk_ra = sp_ff[pse_pkg::SaWidth-1:0] - pse_pkg::SaWidth'(1);
            a_in = stk_rd_ff;
         end
         pse_pkg::ST_RDWAIT: begin
            b_in = stk_rd_ff;
         end
         pse_pkg::ST_OPER: begin
            sp_in  = sp_ff - pse_pkg::SpWidth'(1);
            acc_in = '0;
            case (req_ff.op)
               pse_pkg::OP_ADD: acc_in = a_ff + b_ff;
               pse_pkg::OP_SUB: acc_in = a_ff - b_ff;
               pse_pkg::OP_MUL: begin
                  mul_a  = a_ff;
                  mul_b  = b_ff;
                  acc_in = mul_p;
               end
               pse_pkg::OP_DIV: begin
                  if (b_ff == '0) begin
                     if (err_ff == pse_pkg::ERR_OK) err_in = pse_pkg::ERR_DIVZERO;
                  end else begin
                     a_in   = a_ff[31] ? 32'd0 - a_ff : a_ff;
                     b_in   = b_ff[31] ? 32'd0 - b_ff : b_ff;
                     neg_in = a_ff[31] ^ b_ff[31];
                     rem_in = '0;
                     cnt_in = '0;
                  end
               end
               pse_pkg::OP_POW: begin
                  if (b_ff[31]) begin
                     if (err_ff == pse_pkg::ERR_OK) err_in = pse_pkg::ERR_NEGEXP;
                  end else begin
                     acc_in = 32'd1;
                  end
               end
               default: acc_in = '0;
            endcase
         end
         pse_pkg::ST_DIV: begin
            // restoring division, one quotient bit per cycle into a_ff
            if (!trial[32]) begin
               rem_in = trial[31:0];
            end else begin
               rem_in = {rem_ff[30:0], a_ff[31]};
            end
            a_in   = {a_ff[30:0], ~trial[32]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               acc_in = neg_ff ? 32'd0 - {a_ff[30:0], ~trial[32]}
                               : {a_ff[30:0], ~trial[32]};
            end
         end
         pse_pkg::ST_POW_MUL: begin
            if (b_ff[0]) begin
               acc_in = mul_p;
            end
         end
         pse_pkg::ST_POW_SQ: begin
            mul_a = a_ff;
            mul_b = a_ff;
            a_in  = mul_p;
            b_in  = {1'b0, b_ff[31:1]};
         end
         pse_pkg::ST_WRITE: begin
            if (req_ff.action == pse_pkg::ACT_APPLY) begin
               stk_we = 1'b1;
               stk_wa = sp_ff[pse_pkg::SaWidth-1:0] - pse_pkg::SaWidth'(1);
            end else if (sp_ff >= pse_pkg::SpWidth'(pse_pkg::StackDepth)) begin
               if (err_ff == pse_pkg::ERR_OK) err_in = pse_pkg::ERR_OVERFLOW;
            end else begin
               stk_we = 1'b1;
               stk_wa = sp_ff[pse_pkg::SaWidth-1:0];
               sp_in  = sp_ff + pse_pkg::SpWidth'(1);
            end
         end
         pse_pkg::ST_VARRD: begin
            if (!vvalid_ff[var_ra] && err_ff == pse_pkg::ERR_OK) begin
               err_in = pse_pkg::ERR_UNSET;
            end
         end
         pse_pkg::ST_VARWAIT: begin
            acc_in = var_rd_ff;
         end
         pse_pkg::ST_FINRD: begin
            stk_ra = '0;
         end
         pse_pkg::ST_FINWAIT: begin
            acc_in = (sp_ff == '0) ? 32'd0 : stk_rd_ff;
         end
         pse_pkg::ST_FINOUT: begin
            rsp_valid_in        = 1'b1;
            rsp_in.result       = acc_ff;
            rsp_in.target_index = req_ff.var_index;
            rsp_in.error_code   = (sp_ff == '0 && err_ff == pse_pkg::ERR_OK)
                                  ? pse_pkg::ERR_UNDERFLOW : err_ff;
            var_we              = 1'b1;
            var_wd              = acc_ff;
            vvalid_in[var_wa]   = 1'b1;
            sp_in               = '0;
            err_in              = pse_pkg::ERR_OK;
         end
         default: begin
         end
      endcase
   end

   `ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `ASSERT_IMPLY(a_sp_range, clock, reset, 1'b1,
      sp_ff <= pse_pkg::SpWidth'(pse_pkg::StackDepth), "stack pointer past depth")
   `ASSERT_NEXT(a_fin_clear, clock, reset, rsp_valid_ff,
      sp_ff == '0 || busy, "stack not cleared after finish")

endmodule

### dv/tb_top.sv
// testbench for the postfix stack evaluator: directed cases, then random expressions
module tb_top;

   localparam int StimCount = 1200;
   localparam longint CycleLimit = 400000;

   typedef struct {
      pse_pkg::req_type req;
      logic             has_exp;
      pse_pkg::rsp_type exp;
   } row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   pse_pkg::req_type req_data = '0;
   logic             rsp_valid;
   pse_pkg::rsp_type rsp_data;

   postfix_stack_evaluator u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [31:0]      eval_stack [pse_pkg::StackDepth];
   int               eval_sp;
   logic [31:0]      var_mem [pse_pkg::VarCount];
   logic             var_set [pse_pkg::VarCount];
   pse_pkg::err_type eval_err;

   pse_pkg::rsp_type expected_q [$];
   pse_pkg::rsp_type typed_q [$];
   logic             typed_has_q [$];
   int               fail_count;
   longint           cycle_count;
   logic             quiet;

   function automatic void note_error(pse_pkg::err_type code);
      if (eval_err == pse_pkg::ERR_OK) eval_err = code;
   endfunction

   function automatic void stack_push(logic [31:0] v);
      if (eval_sp >= pse_pkg::StackDepth) begin
         note_error(pse_pkg::ERR_OVERFLOW);
      end else begin
         eval_stack[eval_sp] = v;
         eval_sp++;
      end
   endfunction

   function automatic logic [31:0] combine(logic [31:0] a, logic [31:0] b, logic [2:0] op);
      logic [31:0] acc, base, ex, ma, mb, q;
      case (op)
         pse_pkg::OP_ADD: return a + b;
         pse_pkg::OP_SUB: return a - b;
         pse_pkg::OP_MUL: return a * b;
         pse_pkg::OP_DIV: begin
            if (b == 0) begin
               note_error(pse_pkg::ERR_DIVZERO);
               return 32'd0;
            end
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            return (a[31] ^ b[31]) ? -q : q;
         end
         pse_pkg::OP_POW: begin
            if (b[31]) begin
               note_error(pse_pkg::ERR_NEGEXP);
               return 32'd0;
            end
            acc = 1;
            base = a;
            ex = b;
            while (ex != 0) begin
               if (ex[0]) acc = acc * base;
               ex = ex >> 1;
               base = base * base;
            end
            return acc;
         end
         default: return 32'd0;
      endcase
   endfunction

   function automatic void evaluate(pse_pkg::req_type r);
      pse_pkg::rsp_type res;
      logic [31:0]      v;
      case (r.action)
         pse_pkg::ACT_PUSH_LIT: stack_push(r.value);
         pse_pkg::ACT_PUSH_VAR: begin
            if (var_set[r.var_index]) stack_push(var_mem[r.var_index]);
            else note_error(pse_pkg::ERR_UNSET);
         end
         pse_pkg::ACT_APPLY: begin
            if (eval_sp < 2) begin
               note_error(pse_pkg::ERR_UNDERFLOW);
            end else begin
               v = combine(eval_stack[eval_sp-2], eval_stack[eval_sp-1], r.op);
               eval_sp--;
               eval_stack[eval_sp-1] = v;
            end
         end
         default: begin
            if (eval_sp == 0) begin
               note_error(pse_pkg::ERR_UNDERFLOW);
               v = 0;
            end else begin
               v = eval_stack[0];
            end
            var_mem[r.var_index] = v;
            var_set[r.var_index] = 1'b1;
            res.result = v;
            res.target_index = r.var_index;
            res.error_code = eval_err;
            expected_q.push_back(res);
            eval_sp = 0;
            eval_err = pse_pkg::ERR_OK;
         end
      endcase
   endfunction

   // result checking
   always @(posedge clock) begin
      if (!reset) begin
         cycle_count++;
         if (cycle_count > CycleLimit) begin
            $display("%0t timeout", $time);
            $display("postfix_stack_evaluator test failed");
            $finish;
         end
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $display("%0t unexpected result %p", $time, rsp_data);
               fail_count++;
            end else begin
               if (rsp_data !== expected_q[0]) begin
                  $display("%0t mismatch: expected %p actual %p", $time,
                           expected_q[0], rsp_data);
                  fail_count++;
               end
               if (typed_has_q[0] && rsp_data !== typed_q[0]) begin
                  $display("%0t table mismatch: expected %p actual %p", $time,
                           typed_q[0], rsp_data);
                  fail_count++;
               end
               void'(expected_q.pop_front());
               void'(typed_q.pop_front());
               void'(typed_has_q.pop_front());
            end
         end
      end
   end

   task automatic send(pse_pkg::req_type r, logic has_exp, pse_pkg::rsp_type exp);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      evaluate(r);
      if (r.action == pse_pkg::ACT_FINISH) begin
         typed_q.push_back(exp);
         typed_has_q.push_back(has_exp);
      end
      @(negedge clock);
   endtask

   function automatic pse_pkg::req_type mk(pse_pkg::action_type a, logic [31:0] v,
                                           logic [7:0] idx, logic [2:0] op);
      pse_pkg::req_type r;
      r.action = a;
      r.value = v;
      r.var_index = idx;
      r.op = op;
      return r;
   endfunction

   function automatic pse_pkg::rsp_type ans(logic [31:0] v, logic [7:0] idx,
                                            pse_pkg::err_type e);
      pse_pkg::rsp_type s;
      s.result = v;
      s.target_index = idx;
      s.error_code = e;
      return s;
   endfunction

   task automatic drain;
      start <= 1'b0;
      do @(negedge clock); while (expected_q.size() != 0);
   endtask

   function automatic pse_pkg::req_type random_leaf;
      int k;
      k = $urandom_range(0, 9);
      if (k < 2 && var_set[$urandom_range(0, 15)])
         return mk(pse_pkg::ACT_PUSH_VAR, 0, 8'($urandom_range(0, 15)), 0);
      case ($urandom_range(0, 3))
         0: return mk(pse_pkg::ACT_PUSH_LIT, $urandom_range(0, 9), 0, 0);
         1: return mk(pse_pkg::ACT_PUSH_LIT, -$urandom_range(0, 9), 0, 0);
         default: return mk(pse_pkg::ACT_PUSH_LIT, $urandom, 8'($urandom), 3'($urandom));
      endcase
   endfunction

   row_type          tbl [$];
   pse_pkg::rsp_type none;

   initial begin
      int depth, n, len;
      pse_pkg::req_type r;
      none = '0;
      fail_count = 0;
      cycle_count = 0;
      quiet = 1'b0;
      eval_sp = 0;
      eval_err = pse_pkg::ERR_OK;
      for (int i = 0; i < pse_pkg::VarCount; i++) var_set[i] = 1'b0;

      // directed table
      tbl.push_back('{mk(pse_pkg::ACT_FINISH, 0, 8'd0, 0), 1,
                      ans(0, 0, pse_pkg::ERR_UNDERFLOW)});
      tbl.push_back('{mk(pse_pkg::ACT_PUSH_VAR, 0, 8'd7, 0), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_PUSH_LIT, 32'h7fffffff, 0, 0), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_FINISH, 0, 8'hff, 0), 1,
                      ans(32'h7fffffff, 8'hff, pse_pkg::ERR_UNSET)});
      tbl.push_back('{mk(pse_pkg::ACT_PUSH_LIT, 32'h80000000, 0, 0), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_PUSH_LIT, 32'hffffffff, 0, 0), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_APPLY, 0, 0, pse_pkg::OP_DIV), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_FINISH, 0, 8'd1, 0), 1,
                      ans(32'h80000000, 1, pse_pkg::ERR_OK)});
      tbl.push_back('{mk(pse_pkg::ACT_PUSH_LIT, 5, 0, 0), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_PUSH_LIT, 0, 0, 0), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_APPLY, 0, 0, pse_pkg::OP_DIV), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_FINISH, 0, 8'd2, 0), 1,
                      ans(0, 2, pse_pkg::ERR_DIVZERO)});
      tbl.push_back('{mk(pse_pkg::ACT_PUSH_LIT, 3, 0, 0), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_PUSH_LIT, -1, 0, 0), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_APPLY, 0, 0, pse_pkg::OP_POW), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_FINISH, 0, 8'd3, 0), 1,
                      ans(0, 3, pse_pkg::ERR_NEGEXP)});
      tbl.push_back('{mk(pse_pkg::ACT_PUSH_LIT, 9, 0, 0), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_PUSH_LIT, 0, 0, 0), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_APPLY, 0, 0, pse_pkg::OP_POW), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_PUSH_VAR, 0, 8'hff, 0), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_APPLY, 0, 0, pse_pkg::OP_SUB), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_PUSH_LIT, 7, 0, 0), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_APPLY, 0, 0, 3'd7), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_APPLY, 0, 0, pse_pkg::OP_ADD), 0, none});
      tbl.push_back('{mk(pse_pkg::ACT_FINISH, 0, 8'd4, 0), 1,
                      ans(0, 4, pse_pkg::ERR_UNDERFLOW)});

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (tbl[i]) send(tbl[i].req, tbl[i].has_exp, tbl[i].exp);

      // overflow, then multiply and power chains
      for (int i = 0; i < pse_pkg::StackDepth + 1; i++)
         send(mk(pse_pkg::ACT_PUSH_LIT, i + 2, 0, 0), 0, none);
      send(mk(pse_pkg::ACT_FINISH, 0, 8'd5, 0), 1, ans(2, 5, pse_pkg::ERR_OVERFLOW));
      send(mk(pse_pkg::ACT_PUSH_LIT, 32'h12345, 0, 0), 0, none);
      send(mk(pse_pkg::ACT_PUSH_LIT, 32'h7fffffff, 0, 0), 0, none);
      send(mk(pse_pkg::ACT_APPLY, 0, 0, pse_pkg::OP_POW), 0, none);
      send(mk(pse_pkg::ACT_PUSH_LIT, 32'hfffff123, 0, 0), 0, none);
      send(mk(pse_pkg::ACT_APPLY, 0, 0, pse_pkg::OP_MUL), 0, none);
      send(mk(pse_pkg::ACT_FINISH, 0, 8'd6, 0), 0, none);
      drain;

      // random expressions, mostly well formed
      n = 0;
      while (n < StimCount) begin
         if (n > StimCount - 150) quiet = 1'b1;
         if (n == StimCount / 2) drain;
         if ($urandom_range(0, 9) == 0) begin
            r = mk(pse_pkg::action_type'(2'($urandom)), $urandom, 8'($urandom),
                   3'($urandom));
            send(r, 0, none);
            n++;
         end else begin
            len = $urandom_range(1, 6);
            depth = 0;
            for (int k = 0; k < 2 * len; k++) begin
               if (depth >= 2 && ($urandom_range(0, 1) == 0 || k >= len)) begin
                  r = mk(pse_pkg::ACT_APPLY, 0, 0, 3'($urandom_range(0, 4)));
                  if (r.op == pse_pkg::OP_POW && $urandom_range(0, 1) == 0) begin
                     send(mk(pse_pkg::ACT_PUSH_LIT, $urandom_range(0, 40), 0, 0), 0, none);
                     n++;
                  end else if ($urandom_range(0, 20) == 0) begin
                     r.op = 3'($urandom_range(5, 7));
                  end
                  send(r, 0, none);
                  depth--;
               end else begin
                  send(random_leaf(), 0, none);
                  depth++;
               end
               n++;
            end
            r = mk(pse_pkg::ACT_FINISH, $urandom, 8'($urandom_range(0, 15)), 3'($urandom));
            if ($urandom_range(0, 7) == 0) r.var_index = 8'($urandom);
            send(r, 0, none);
            n++;
         end
      end

      drain;
      repeat (80) @(posedge clock);
      if (fail_count == 0) begin
         $display("postfix_stack_evaluator test passed");
      end else begin
         $display("postfix_stack_evaluator test failed");
      end
      $finish;
   end
endmodule

### postfix_stack_evaluator.f
+incdir+src
src/pse_pkg.sv
src/postfix_stack_evaluator.sv
dv/tb_top.sv
